>>> sv/der_sd_pkg.sv
`default_nettype none

package der_sd_pkg;

  // DER tag values and bit masks
  localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
  localparam logic [7:0] TAG_INTEGER   = 8'h02;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam int unsigned SIGN_BIT_POS = 7;

  // Shortest legal signature, in bytes
  localparam logic [6:0] MIN_SIG_BYTES = 7'd8;
  // Saturation value of the byte counter
  localparam logic [6:0] BYTE_COUNT_MAX = 7'd127;
  // An integer element is never longer than 63 bytes
  localparam int unsigned ELEM_CNT_W = 6;

  // Position in the DER layout
  typedef enum logic [3:0] {
    PH_SEQ   = 4'd0,
    PH_TOTAL = 4'd1,
    PH_RTAG  = 4'd2,
    PH_RLEN  = 4'd3,
    PH_RDATA = 4'd4,
    PH_STAG  = 4'd5,
    PH_SLEN  = 4'd6,
    PH_SDATA = 4'd7,
    PH_DONE  = 4'd8
  } phase_t;

  // One input request: a signature byte and its end marker
  typedef struct packed {
    logic [7:0] sig_byte;
    logic       last_byte;
  } sig_req_t;

  // One result item: data byte or verdict
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_s_element;
    logic       valid_res;
    logic       final_res;
  } res_t;

  // Results of one byte, handed from checker to output queue
  typedef struct packed {
    logic data_push;
    res_t data;
    logic verdict_push;
    res_t verdict;
  } chk_out_t;

endpackage

`default_nettype wire

>>> sv/der_signature_decoder_unit.sv
// Strict DER signature decoder. Signature bytes arrive one request per cycle on
// sig_data, with last_byte set on the final byte. Each byte is checked against the
// layout 0x30, total, 0x02, rlen, R, 0x02, slen, S; R and S bytes come out on
// res_data as they arrive (is_s_element tells which), with a sign-pad zero
// removed, and after the last byte a verdict item (final_res = 1) carries
// valid_res. Data bytes of a run whose verdict is 0 must be dropped by the user.
// Throughput is one byte per cycle while the output queue has room: a byte is
// held in the input register, checked there, and its results are written into a
// four-entry output queue whose fill count drives res_valid. A final byte that
// also yields a data item puts two items in the queue; input stalls only while the
// queue holds more than two items.
`default_nettype none

module der_signature_decoder_unit #(
  parameter int unsigned MAX_SIG_BYTES     = 72,
  parameter int unsigned MAX_ELEMENT_BYTES = 33
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sig_valid,
  output logic                      sig_ready,
  input  wire der_sd_pkg::sig_req_t sig_data,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output der_sd_pkg::res_t          res_data
);
  import der_sd_pkg::*;

  sig_req_t ir_req;
  logic     ir_valid;
  logic     room;
  logic     take;
  chk_out_t chk;

  // Input register drains into the checker whenever the queue has room
  assign take      = ir_valid && room;
  assign sig_ready = !ir_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (sig_ready) begin
      ir_valid <= sig_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sig_ready && sig_valid) ir_req <= sig_data;
  end

  der_sd_check #(
    .MAX_SIG_BYTES    (MAX_SIG_BYTES),
    .MAX_ELEMENT_BYTES(MAX_ELEMENT_BYTES)
  ) u_check (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .req   (ir_req),
    .result(chk)
  );

  der_sd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (chk),
    .room     (room),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

endmodule

`default_nettype wire

>>> sv/der_sd_check.sv
`default_nettype none

module der_sd_check #(
  parameter int unsigned MAX_SIG_BYTES     = 72,
  parameter int unsigned MAX_ELEMENT_BYTES = 33
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire der_sd_pkg::sig_req_t req,
  output der_sd_pkg::chk_out_t      result
);
  import der_sd_pkg::*;

  localparam logic [7:0] MAX_SIG  = 8'(MAX_SIG_BYTES);
  localparam logic [7:0] MAX_ELEM = 8'(MAX_ELEMENT_BYTES);

  // Run state
  phase_t                phase, phase_next;
  logic [6:0]            byte_count, byte_count_next;
  logic [7:0]            declared_total, declared_total_next;
  logic [7:0]            r_length, r_length_next;
  logic [7:0]            s_length, s_length_next;
  logic [ELEM_CNT_W-1:0] element_count, element_count_next;
  logic                  first_zero, first_zero_next;
  logic                  error_seen, error_seen_next;

  logic [7:0] b;
  logic [7:0] cnt;
  logic [7:0] cur_len;
  logic [7:0] elem_cnt_inc;
  logic [8:0] len_sum;
  logic       emit;
  logic       ok;

  assign b = req.sig_byte;

  // Per-byte layout checks and state update
  always_comb begin
    cnt                 = {1'b0, byte_count} + 8'd1;
    phase_next          = phase;
    declared_total_next = declared_total;
    r_length_next       = r_length;
    s_length_next       = s_length;
    element_count_next  = element_count;
    first_zero_next     = first_zero;
    error_seen_next     = error_seen | (cnt > MAX_SIG);
    byte_count_next     = cnt[7] ? BYTE_COUNT_MAX : cnt[6:0];
    cur_len             = (phase == PH_SDATA) ? s_length : r_length;
    elem_cnt_inc        = 8'(element_count) + 8'd1;
    len_sum             = {1'b0, r_length} + {1'b0, b} + 9'd4;
    emit                = 1'b0;

    if (!error_seen_next) begin
      unique case (phase)
        PH_SEQ: begin
          if (b != TAG_SEQUENCE) error_seen_next = 1'b1;
          else phase_next = PH_TOTAL;
        end
        PH_TOTAL: begin
          declared_total_next = b;
          phase_next          = PH_RTAG;
        end
        PH_RTAG, PH_STAG: begin
          if (b != TAG_INTEGER) error_seen_next = 1'b1;
          else phase_next = (phase == PH_RTAG) ? PH_RLEN : PH_SLEN;
        end
        PH_RLEN: begin
          r_length_next = b;
          if (b == BYTE_ZERO || b > MAX_ELEM) error_seen_next = 1'b1;
          else phase_next = PH_RDATA;
        end
        PH_SLEN: begin
          s_length_next = b;
          if (b == BYTE_ZERO || b > MAX_ELEM || len_sum != {1'b0, declared_total})
            error_seen_next = 1'b1;
          else
            phase_next = PH_SDATA;
        end
        PH_RDATA, PH_SDATA: begin
          emit = 1'b1;
          if (element_count == '0) begin
            // negative integer, or a stripped sign pad
            first_zero_next = (b == BYTE_ZERO);
            if (b[SIGN_BIT_POS]) begin
              error_seen_next = 1'b1;
              emit            = 1'b0;
            end else if (cur_len > 8'd1 && b == BYTE_ZERO) begin
              emit = 1'b0;
            end
          end else if (element_count == ELEM_CNT_W'(1) && first_zero) begin
            // pad is only allowed ahead of a byte with its top bit set
            if (!b[SIGN_BIT_POS]) begin
              error_seen_next = 1'b1;
              emit            = 1'b0;
            end
          end
          if (!error_seen_next) begin
            element_count_next = element_count + ELEM_CNT_W'(1);
            if (elem_cnt_inc >= cur_len) begin
              phase_next         = (phase == PH_RDATA) ? PH_STAG : PH_DONE;
              element_count_next = '0;
              first_zero_next    = 1'b0;
            end
          end
        end
        default: error_seen_next = 1'b1;
      endcase
    end

    ok = !error_seen_next && phase_next == PH_DONE &&
         byte_count_next >= MIN_SIG_BYTES &&
         {1'b0, byte_count_next} <= MAX_SIG &&
         ({1'b0, declared_total_next} + 9'd2) == {2'b0, byte_count_next};

    result.data_push              = take && emit && !error_seen_next;
    result.data.out_byte          = b;
    result.data.is_s_element      = (phase == PH_SDATA);
    result.data.valid_res         = 1'b0;
    result.data.final_res         = 1'b0;
    result.verdict_push           = take && req.last_byte;
    result.verdict.out_byte       = BYTE_ZERO;
    result.verdict.is_s_element   = 1'b0;
    result.verdict.valid_res      = ok;
    result.verdict.final_res      = 1'b1;
  end

  // State registers; the last byte of a run returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (take && req.last_byte)) begin
      phase          <= PH_SEQ;
      byte_count     <= '0;
      declared_total <= '0;
      r_length       <= '0;
      s_length       <= '0;
      element_count  <= '0;
      first_zero     <= 1'b0;
      error_seen     <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      declared_total <= declared_total_next;
      r_length       <= r_length_next;
      s_length       <= s_length_next;
      element_count  <= element_count_next;
      first_zero     <= first_zero_next;
      error_seen     <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/der_sd_outq.sv
`default_nettype none

module der_sd_outq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire der_sd_pkg::chk_out_t push,
  output logic                      room,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output der_sd_pkg::res_t          res_data
);
  import der_sd_pkg::*;

  // Four-entry result queue, up to two writes per cycle
  res_t       entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;
  logic [1:0] n_push;

  assign pop       = res_valid && res_ready;
  assign res_valid = (count != 3'd0);
  assign res_data  = entries[rd_ptr];
  // two free slots before the current occupancy drains
  assign room      = (count <= 3'd2);
  assign n_push    = 2'(push.data_push) + 2'(push.verdict_push);

  // Entry writes: data item first, verdict after it
  always_ff @(posedge clk) begin
    if (push.data_push) begin
      entries[wr_ptr] <= push.data;
      if (push.verdict_push) entries[wr_ptr + 2'd1] <= push.verdict;
    end else if (push.verdict_push) begin
      entries[wr_ptr] <= push.verdict;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(n_push) - 3'(pop);
    end
  end

endmodule

`default_nettype wire

>>> tb/der_signature_decoder_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the DER signature decoder, predicts the result
// items of every accepted signature byte and compares them in order.
module der_signature_decoder_checker #(
  parameter int unsigned MAX_SIG_BYTES     = 72,
  parameter int unsigned MAX_ELEMENT_BYTES = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sig_valid,
  input  logic                 sig_ready,
  input  der_sd_pkg::sig_req_t sig_data,
  input  logic                 res_valid,
  input  logic                 res_ready,
  input  der_sd_pkg::res_t     res_data,
  output int                   mismatch_count,
  output int                   awaited_count,
  output int                   checked_count
);
  import der_sd_pkg::*;

  // Predicted decoder state for the signature in progress
  phase_t     der_phase;
  logic [6:0] seen_bytes;
  logic [7:0] total_len;
  logic [7:0] r_len;
  logic [7:0] s_len;
  logic [7:0] int_count;
  logic [7:0] int_first;
  logic       failed;

  res_t pending_results[$];
  res_t exp_item;
  int   fail_tally = 0;
  int   check_tally = 0;

  task automatic clear_run();
    der_phase  = PH_SEQ;
    seen_bytes = '0;
    total_len  = '0;
    r_len      = '0;
    s_len      = '0;
    int_count  = '0;
    int_first  = '0;
    failed     = 1'b0;
  endtask

  // One byte of R or S: sign check, padding check, and stripping of a pad zero
  task automatic take_int_byte(input logic [7:0] b, input logic [7:0] len,
                               input phase_t nxt, output logic emit);
    emit = 1'b1;
    if (int_count == 8'd0 && b[SIGN_BIT_POS]) begin
      failed = 1'b1;
      emit   = 1'b0;
    end else if (int_count == 8'd1 && int_first == BYTE_ZERO && !b[SIGN_BIT_POS]) begin
      failed = 1'b1;
      emit   = 1'b0;
    end else begin
      if (int_count == 8'd0) begin
        int_first = b;
        if (len > 8'd1 && b == BYTE_ZERO) emit = 1'b0;
      end
      int_count = int_count + 8'd1;
      if (int_count >= len) begin
        der_phase = nxt;
        int_count = '0;
        int_first = '0;
      end
    end
  endtask

  // Work out the result items of one accepted request
  task automatic predict_byte(input sig_req_t req);
    logic [7:0] b;
    int         cnt;
    logic       emit;
    logic       is_s;
    res_t       item;

    b    = req.sig_byte;
    emit = 1'b0;
    is_s = 1'b0;
    cnt  = int'(seen_bytes) + 1;
    if (cnt > int'(MAX_SIG_BYTES)) failed = 1'b1;
    seen_bytes = (cnt > int'(BYTE_COUNT_MAX)) ? BYTE_COUNT_MAX : 7'(cnt);

    if (!failed) begin
      case (der_phase)
        PH_SEQ: begin
          if (b != TAG_SEQUENCE) failed = 1'b1;
          else der_phase = PH_TOTAL;
        end
        PH_TOTAL: begin
          total_len = b;
          der_phase = PH_RTAG;
        end
        PH_RTAG: begin
          if (b != TAG_INTEGER) failed = 1'b1;
          else der_phase = PH_RLEN;
        end
        PH_RLEN: begin
          r_len = b;
          if (b == 8'd0 || b > MAX_ELEMENT_BYTES) failed = 1'b1;
          else der_phase = PH_RDATA;
        end
        PH_RDATA: begin
          take_int_byte(b, r_len, PH_STAG, emit);
        end
        PH_STAG: begin
          if (b != TAG_INTEGER) failed = 1'b1;
          else der_phase = PH_SLEN;
        end
        PH_SLEN: begin
          s_len = b;
          // total length is cross-checked here and again against the byte count at the verdict
          if (b == 8'd0 || b > MAX_ELEMENT_BYTES ||
              int'(r_len) + int'(s_len) + 4 != int'(total_len))
            failed = 1'b1;
          else
            der_phase = PH_SDATA;
        end
        PH_SDATA: begin
          is_s = 1'b1;
          take_int_byte(b, s_len, PH_DONE, emit);
        end
        default: begin
          // anything after the last S byte
          failed = 1'b1;
        end
      endcase
    end

    if (emit && !failed) begin
      item.out_byte     = b;
      item.is_s_element = is_s;
      item.valid_res    = 1'b0;
      item.final_res    = 1'b0;
      pending_results.push_back(item);
    end

    // Verdict on the final byte, then back to a fresh signature
    if (req.last_byte) begin
      item.out_byte     = '0;
      item.is_s_element = 1'b0;
      item.valid_res    = !failed && der_phase == PH_DONE &&
                          seen_bytes >= MIN_SIG_BYTES &&
                          int'(seen_bytes) <= int'(MAX_SIG_BYTES) &&
                          int'(total_len) + 2 == int'(seen_bytes);
      item.final_res    = 1'b1;
      pending_results.push_back(item);
      clear_run();
    end
  endtask

  // Compare accepted results first, then predict from the accepted request
  always @(posedge clk) begin
    if (rst) begin
      clear_run();
      pending_results.delete();
    end else begin
      if (res_valid && res_ready) begin
        check_tally++;
        if (pending_results.size() == 0) begin
          if (fail_tally < 10)
            $display("%0t: result with none pending: byte %02h s %0b valid %0b final %0b",
                     $time, res_data.out_byte, res_data.is_s_element,
                     res_data.valid_res, res_data.final_res);
          fail_tally++;
        end else begin
          exp_item = pending_results.pop_front();
          if (res_data.out_byte !== exp_item.out_byte ||
              res_data.is_s_element !== exp_item.is_s_element ||
              res_data.valid_res !== exp_item.valid_res ||
              res_data.final_res !== exp_item.final_res) begin
            if (fail_tally < 10)
              $display({"%0t: mismatch: expected byte %02h s %0b valid %0b final %0b,",
                        " got byte %02h s %0b valid %0b final %0b"}, $time,
                       exp_item.out_byte, exp_item.is_s_element,
                       exp_item.valid_res, exp_item.final_res,
                       res_data.out_byte, res_data.is_s_element,
                       res_data.valid_res, res_data.final_res);
            fail_tally++;
          end
        end
      end
      if (sig_valid && sig_ready) predict_byte(sig_data);
    end
    mismatch_count <= fail_tally;
    awaited_count  <= pending_results.size();
    checked_count  <= check_tally;
  end

endmodule

>>> tb/der_signature_decoder_unit_test.sv
`timescale 1ns / 1ps

module der_signature_decoder_unit_test;
  import der_sd_pkg::*;

  localparam int unsigned SIG_LIMIT  = 72;
  localparam int unsigned ELEM_LIMIT = 33;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_BYTES = 950;
  localparam int HOLD_CYCLES  = 300;

  // Ways a random signature can be spoiled
  typedef enum int {
    CUT_NONE, CUT_SEQ_TAG, CUT_R_TAG, CUT_S_TAG, CUT_TOTAL, CUT_R_LEN,
    CUT_S_LEN, CUT_NEG, CUT_PAD, CUT_EARLY, CUT_EXTRA, CUT_NOISE
  } flaw_t;

  typedef enum int {INT_OK, INT_NEG, INT_BADPAD} int_form_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     sig_valid = 1'b0;
  logic     sig_ready;
  sig_req_t sig_data = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  res_t     res_data;

  int mismatch_count;
  int awaited_count;
  int checked_count;
  int cycles = 0;
  int bytes_sent = 0;
  int runs_sent = 0;

  logic quiet = 1'b0;
  logic long_hold = 1'b0;
  logic [7:0] run_bytes[$];

  der_signature_decoder_unit #(
    .MAX_SIG_BYTES     (SIG_LIMIT),
    .MAX_ELEMENT_BYTES (ELEM_LIMIT)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .sig_valid (sig_valid),
    .sig_ready (sig_ready),
    .sig_data  (sig_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  der_signature_decoder_checker #(
    .MAX_SIG_BYTES     (SIG_LIMIT),
    .MAX_ELEMENT_BYTES (ELEM_LIMIT)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .sig_valid      (sig_valid),
    .sig_ready      (sig_ready),
    .sig_data       (sig_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_data       (res_data),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still pending", cycles, awaited_count);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int k;
    forever begin
      if (long_hold) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, 10);
        res_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end else begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        res_ready <= 1'b1;
        repeat (k) @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] with_sign(logic [7:0] v, logic s);
    v[SIGN_BIT_POS] = s;
    return v;
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] tag);
    logic [7:0] v;
    v = 8'($urandom);
    if (v == tag) v = ~v;
    return v;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return int'(ELEM_LIMIT);
    if (r < 4) return $urandom_range(5, ELEM_LIMIT - 1);
    return $urandom_range(1, 4);
  endfunction

  // Append the bytes of one integer of n bytes
  function automatic void fill_integer(int n, int_form_t form);
    int k;
    k = 0;
    if (n == 1) begin
      if (form == INT_NEG) run_bytes.push_back(with_sign(8'($urandom), 1'b1));
      else if ($urandom_range(0, 3) == 0) run_bytes.push_back(BYTE_ZERO);
      else run_bytes.push_back(with_sign(8'($urandom), 1'b0));
      k = 1;
    end else begin
      case (form)
        INT_NEG: begin
          run_bytes.push_back(with_sign(8'($urandom), 1'b1));
          k = 1;
        end
        INT_BADPAD: begin
          run_bytes.push_back(BYTE_ZERO);
          run_bytes.push_back(with_sign(8'($urandom), 1'b0));
          k = 2;
        end
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            run_bytes.push_back(BYTE_ZERO);
            run_bytes.push_back(with_sign(8'($urandom), 1'b1));
            k = 2;
          end else begin
            run_bytes.push_back(with_sign(8'($urandom_range(1, 255)), 1'b0) | 8'h01);
            k = 1;
          end
        end
      endcase
    end
    while (k < n) begin
      run_bytes.push_back(8'($urandom));
      k++;
    end
  endfunction

  // Build one signature with random content and at most one flaw
  function automatic void build_run(flaw_t flaw);
    int         rlen;
    int         slen;
    int         side;
    int         keep;
    int         n;
    logic [7:0] total;
    logic [7:0] rlen_byte;
    logic [7:0] slen_byte;
    int_form_t  form;

    run_bytes.delete();
    if (flaw == CUT_NOISE) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 20);
      repeat (n) run_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 1) run_bytes[0] = TAG_SEQUENCE;
    end else begin
      rlen = pick_len();
      slen = pick_len();
      side = $urandom_range(0, 1);
      form = (flaw == CUT_NEG) ? INT_NEG : (flaw == CUT_PAD) ? INT_BADPAD : INT_OK;
      if (flaw == CUT_PAD && side == 0 && rlen < 2) rlen = 2;
      if (flaw == CUT_PAD && side == 1 && slen < 2) slen = 2;

      total = 8'(rlen + slen + 4);
      if (flaw == CUT_TOTAL) total = total + 8'($urandom_range(1, 255));
      rlen_byte = 8'(rlen);
      slen_byte = 8'(slen);
      if (flaw == CUT_R_LEN)
        rlen_byte = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(ELEM_LIMIT + 1, 255));
      if (flaw == CUT_S_LEN)
        slen_byte = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(ELEM_LIMIT + 1, 255));

      run_bytes.push_back((flaw == CUT_SEQ_TAG) ? other_than(TAG_SEQUENCE) : TAG_SEQUENCE);
      run_bytes.push_back(total);
      run_bytes.push_back((flaw == CUT_R_TAG) ? other_than(TAG_INTEGER) : TAG_INTEGER);
      run_bytes.push_back(rlen_byte);
      fill_integer(rlen, (side == 0) ? form : INT_OK);
      run_bytes.push_back((flaw == CUT_S_TAG) ? other_than(TAG_INTEGER) : TAG_INTEGER);
      run_bytes.push_back(slen_byte);
      fill_integer(slen, (side == 1) ? form : INT_OK);

      if (flaw == CUT_EARLY) begin
        keep = $urandom_range(1, run_bytes.size() - 1);
        while (run_bytes.size() > keep) void'(run_bytes.pop_back());
      end
      if (flaw == CUT_EXTRA) repeat ($urandom_range(1, 4)) run_bytes.push_back(8'($urandom));
    end
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      sig_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sig_data  <= {b, last};
    sig_valid <= 1'b1;
    @(posedge clk);
    while (!sig_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_run();
    for (int i = 0; i < run_bytes.size(); i++)
      send_byte(run_bytes[i], i == run_bytes.size() - 1);
    runs_sent++;
  endtask

  // Stimulus and verdict
  initial begin
    flaw_t flaw;
    logic  hold_done;
    logic  pause_done;

    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Shortest legal signature, one-byte zero R
    run_bytes = '{TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01, BYTE_ZERO,
                  TAG_INTEGER, 8'h01, 8'h7f};
    send_run();
    // Both integers carry a sign pad that must be stripped
    run_bytes = '{TAG_SEQUENCE, 8'h08, TAG_INTEGER, 8'h02, BYTE_ZERO, 8'h80,
                  TAG_INTEGER, 8'h02, BYTE_ZERO, 8'hff};
    send_run();
    // Ends inside the header
    run_bytes = '{TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01};
    send_run();
    // Lone byte with a wrong tag
    run_bytes = '{8'hff};
    send_run();

    while (bytes_sent < TARGET_BYTES) begin
      if (!hold_done && bytes_sent >= 150) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && bytes_sent >= 500) begin
        sig_valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0) @(posedge clk);
        pause_done = 1'b1;
      end
      if (bytes_sent >= TARGET_BYTES * 17 / 20) quiet = 1'b1;
      flaw = ($urandom_range(0, 9) < 6) ? CUT_NONE : flaw_t'($urandom_range(1, 11));
      build_run(flaw);
      send_run();
    end

    // Drain
    sig_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d signatures (%0d bytes), including spoiled and noise runs.",
             runs_sent, bytes_sent);
    $display("Checked %0d result items, %0d mismatches.", checked_count, mismatch_count);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
